/* rtl/core/dds_pkg.sv */
package dds_pkg;

    localparam int DIGIT_W = 4;
    localparam int MODE_W  = 2;
    localparam int CHG_W   = 17;
    localparam int ROLL_W  = 8;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 2;

    localparam logic [MODE_W-1:0] MODE_TIME = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROLL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DATE = 2'd2;

    localparam logic [ADDR_W-1:0] REG_TIME_HOLD = 2'd0;
    localparam logic [ADDR_W-1:0] REG_DATE_HOLD = 2'd1;
    localparam logic [ADDR_W-1:0] REG_ROLL_STEP = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SETTLE    = 2'd3;

    localparam logic [15:0] TIME_HOLD_RST = 16'd65000;
    localparam logic [15:0] DATE_HOLD_RST = 16'd5000;
    localparam logic [7:0]  ROLL_STEP_RST = 8'd90;
    localparam logic [7:0]  SETTLE_RST    = 8'd10;

    localparam logic [CHG_W-1:0]  CHG_MAX  = '1;
    localparam logic [ROLL_W-1:0] ROLL_MAX = '1;

    typedef struct packed {
        logic [15:0] time_hold_ms;
        logic [15:0] date_hold_ms;
        logic [7:0]  roll_step_ms;
        logic [7:0]  settle_steps;
    } cfg_t;

endpackage

/* rtl/core/dds_cfg_regs.sv */
module dds_cfg_regs
    import dds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_TIME_HOLD: cfg_next.time_hold_ms = cfg_data;
                REG_DATE_HOLD: cfg_next.date_hold_ms = cfg_data;
                REG_ROLL_STEP: cfg_next.roll_step_ms = cfg_data[7:0];
                REG_SETTLE:    cfg_next.settle_steps = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_hold_ms <= TIME_HOLD_RST;
            cfg_reg.date_hold_ms <= DATE_HOLD_RST;
            cfg_reg.roll_step_ms <= ROLL_STEP_RST;
            cfg_reg.settle_steps <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/dds_lane.sv */
module dds_lane
    import dds_pkg::*;
(
    input  logic [DIGIT_W-1:0] shown,
    input  logic [DIGIT_W-1:0] time_digit,
    input  logic [DIGIT_W-1:0] date_digit,
    input  logic               to_date,
    input  logic               settle_ok,
    output logic [DIGIT_W-1:0] next_digit,
    output logic               match
);

    logic [DIGIT_W-1:0] goal;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W-1:0] advanced;

    assign goal = to_date ? date_digit : time_digit;
    assign sum  = {1'b0, shown} + {{DIGIT_W{1'b0}}, 1'b1};

    // (d + 1) mod 10; sum never reaches 20, so one subtract is enough
    assign advanced = (sum >= (DIGIT_W+1)'(10)) ? DIGIT_W'(sum - (DIGIT_W+1)'(10))
                                                : sum[DIGIT_W-1:0];

    // hold a digit that already sits on its goal once settling is allowed
    assign next_digit = (shown == goal && settle_ok) ? shown : advanced;
    assign match      = (next_digit == goal);

endmodule

/* rtl/core/digit_display_mode_sequencer.sv */
// Digit display mode sequencer: one millisecond tick item in, one display item out.
// The block accepts an item in every cycle while the output is not stalled; each item
// passes an input register and is resolved against the mode, digit, roll-count and timer
// state, landing in the result register that drives the output. The state update is
// done once per tick, which sets that rate. While the result register is full and stalled,
// one more item is held in the input register before s_tready drops. No clearing pass after
// reset: the block is ready at once. Configuration writes take effect on the next edge
// and are meant to be made while no items are in flight.
module digit_display_mode_sequencer
    import dds_pkg::*;
#(
    parameter int LAMPS = 4,
    localparam int IN_W  = ((2 * LAMPS * DIGIT_W + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((LAMPS * DIGIT_W + 2 + MODE_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // time_digit_0..LAMPS-1, date_digit_0..LAMPS-1, second_odd, zero pad
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // shown_digit_0..LAMPS-1, lower_dot, upper_dot, mode, zero pad
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int DIG_BITS = LAMPS * DIGIT_W;
    localparam int IN_BITS  = 2 * DIG_BITS + 1;
    localparam int OUT_BITS = DIG_BITS + 2 + MODE_W;

    cfg_t cfg;

    logic                in_valid_reg, in_valid_next;
    logic [IN_BITS-1:0]  in_data_reg, in_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg, out_data_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                target_reg, target_next;
    logic [LAMPS-1:0][DIGIT_W-1:0] digits_reg, digits_next;
    logic [ROLL_W-1:0]   roll_cnt_reg, roll_cnt_next;
    logic [CHG_W-1:0]    chg_ms_reg, chg_ms_next;
    logic [ROLL_W-1:0]   roll_ms_reg, roll_ms_next;

    logic                in_fire;
    logic [LAMPS-1:0][DIGIT_W-1:0] time_digits, date_digits, rolled;
    logic [LAMPS-1:0]    lane_match;
    logic                parity;
    logic                settle_ok;
    logic [CHG_W-1:0]    chg_inc;
    logic [ROLL_W-1:0]   roll_inc;
    logic                lower_dot, upper_dot;

    dds_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign time_digits = in_data_reg[DIG_BITS-1:0];
    assign date_digits = in_data_reg[2*DIG_BITS-1:DIG_BITS];
    assign parity      = in_data_reg[2*DIG_BITS];
    assign settle_ok   = (roll_cnt_reg > cfg.settle_steps);

    for (genvar g = 0; g < LAMPS; g++)
    begin : g_lane
        dds_lane u_lane (
            .shown      (digits_reg[g]),
            .time_digit (time_digits[g]),
            .date_digit (date_digits[g]),
            .to_date    (target_reg),
            .settle_ok  (settle_ok),
            .next_digit (rolled[g]),
            .match      (lane_match[g])
        );
    end

    // handshake: the input stage drains whenever the result register can take an item
    assign in_fire  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_data_next  = s_tdata[IN_BITS-1:0];
        end
        else if (in_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    assign chg_inc  = (chg_ms_reg == CHG_MAX) ? chg_ms_reg : chg_ms_reg + CHG_W'(1);
    assign roll_inc = (roll_ms_reg == ROLL_MAX) ? roll_ms_reg : roll_ms_reg + ROLL_W'(1);

    always_comb
    begin
        mode_next     = mode_reg;
        target_next   = target_reg;
        digits_next   = digits_reg;
        roll_cnt_next = roll_cnt_reg;
        chg_ms_next   = chg_ms_reg;
        roll_ms_next  = roll_ms_reg;
        lower_dot     = 1'b1;
        upper_dot     = 1'b0;
        if (in_fire)
        begin
            chg_ms_next  = chg_inc;
            roll_ms_next = roll_inc;
            case (mode_reg)
                MODE_TIME:
                begin
                    digits_next = time_digits;
                    lower_dot   = parity;
                    upper_dot   = parity;
                    if (chg_inc > {1'b0, cfg.time_hold_ms})
                    begin
                        mode_next   = MODE_ROLL;
                        target_next = 1'b1;
                        chg_ms_next = '0;
                    end
                end
                MODE_DATE:
                begin
                    digits_next = date_digits;
                    if (chg_inc > {1'b0, cfg.date_hold_ms})
                    begin
                        mode_next   = MODE_ROLL;
                        target_next = 1'b0;
                        chg_ms_next = '0;
                    end
                end
                default:
                begin
                    if (roll_inc >= cfg.roll_step_ms)
                    begin
                        roll_ms_next  = '0;
                        digits_next   = rolled;
                        roll_cnt_next = roll_cnt_reg + ROLL_W'(1);
                        if (&lane_match)
                        begin
                            mode_next     = target_reg ? MODE_DATE : MODE_TIME;
                            roll_cnt_next = '0;
                            chg_ms_next   = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {mode_next, upper_dot, lower_dot, digits_next};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_ROLL;
            target_reg    <= 1'b0;
            digits_reg    <= '0;
            roll_cnt_reg  <= '0;
            chg_ms_reg    <= '0;
            roll_ms_reg   <= ROLL_MAX;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            target_reg    <= target_next;
            digits_reg    <= digits_next;
            roll_cnt_reg  <= roll_cnt_next;
            chg_ms_reg    <= chg_ms_next;
            roll_ms_reg   <= roll_ms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

/* rtl/core/dds_checker.sv */
module dds_checker
    import dds_pkg::*;
#(
    parameter int LAMPS = 4,
    localparam int OUT_W = ((LAMPS * DIGIT_W + 2 + MODE_W + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int LO_BIT   = LAMPS * DIGIT_W;
    localparam int UP_BIT   = LO_BIT + 1;
    localparam int MODE_LSB = LO_BIT + 2;

    logic [MODE_W-1:0] out_mode;

    assign out_mode = m_tdata[MODE_LSB +: MODE_W];

    // the unused mode code never leaves the block
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_mode == MODE_TIME || out_mode == MODE_ROLL
                      || out_mode == MODE_DATE))
        else $error("mode code out of range");

    // date items, including the arrival tick, carry the fixed separators
    a_date_dots: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_mode == MODE_DATE) |-> (m_tdata[LO_BIT] && !m_tdata[UP_BIT]))
        else $error("date item with wrong dots");

    // an empty output side must never block the input side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output item changed");

endmodule

bind digit_display_mode_sequencer dds_checker #(.LAMPS(LAMPS)) u_dds_checker (.*);

/* sim/dds_display_checker.sv */
module dds_display_checker
    import dds_pkg::*;
#(
    parameter int LAMPS = 4,
    parameter int IN_W  = 40,
    parameter int OUT_W = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int                errors,
    output int                pending,
    output int                checked,
    output int                arrivals,
    output int                switches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_W = 2 * LAMPS * DIGIT_W + 1;
    localparam int SHOW_W = LAMPS * DIGIT_W + 2 + MODE_W;

    typedef logic [LAMPS-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic    second_odd;
        digits_t date_digit;
        digits_t time_digit;
    } tick_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              upper_dot;
        logic              lower_dot;
        digits_t           shown;
    } display_t;

    cfg_t              regs;
    logic [MODE_W-1:0] cur_mode;
    logic              toward_date;
    digits_t           shown_digits;
    logic [7:0]        roll_cnt;
    logic [CHG_W-1:0]  since_change;
    logic [ROLL_W-1:0] since_roll;
    display_t          display_q[$];
    display_t          want;
    display_t          got;

    function automatic display_t advance_display(tick_t t);
        display_t           r;
        digits_t            goal;
        logic [DIGIT_W-1:0] d;
        logic               all_match;
        if (since_change != CHG_MAX)
            since_change++;
        if (since_roll != ROLL_MAX)
            since_roll++;
        r.lower_dot = 1'b1;
        r.upper_dot = 1'b0;
        case (cur_mode)
            MODE_TIME:
            begin
                if (since_change > {1'b0, regs.time_hold_ms})
                begin
                    cur_mode     = MODE_ROLL;
                    toward_date  = 1'b1;
                    since_change = '0;
                    switches++;
                end
                shown_digits = t.time_digit;
                r.lower_dot  = t.second_odd;
                r.upper_dot  = t.second_odd;
            end
            MODE_DATE:
            begin
                if (since_change > {1'b0, regs.date_hold_ms})
                begin
                    cur_mode     = MODE_ROLL;
                    toward_date  = 1'b0;
                    since_change = '0;
                    switches++;
                end
                shown_digits = t.date_digit;
            end
            default:
            begin
                if (since_roll >= regs.roll_step_ms)
                begin
                    since_roll = '0;
                    goal       = toward_date ? t.date_digit : t.time_digit;
                    all_match  = 1'b1;
                    for (int i = 0; i < LAMPS; i++)
                    begin
                        d = shown_digits[i];
                        // a matching digit holds only once the roll count passes settle
                        if (!(d == goal[i] && roll_cnt > regs.settle_steps))
                            d = DIGIT_W'((int'(d) + 1) % 10);
                        shown_digits[i] = d;
                        if (d != goal[i])
                            all_match = 1'b0;
                    end
                    roll_cnt++;
                    if (all_match)
                    begin
                        cur_mode     = toward_date ? MODE_DATE : MODE_TIME;
                        roll_cnt     = '0;
                        since_change = '0;
                        arrivals++;
                    end
                end
            end
        endcase
        r.shown = shown_digits;
        r.mode  = cur_mode;
        return r;
    endfunction

    task automatic check_display(display_t w, display_t g);
        for (int i = 0; i < LAMPS; i++)
        begin
            if (g.shown[i] !== w.shown[i])
            begin
                $error("shown_digit_%0d: expected %0d, actual %0d", i, w.shown[i], g.shown[i]);
                errors++;
            end
        end
        if (g.lower_dot !== w.lower_dot)
        begin
            $error("lower_dot: expected %0d, actual %0d", w.lower_dot, g.lower_dot);
            errors++;
        end
        if (g.upper_dot !== w.upper_dot)
        begin
            $error("upper_dot: expected %0d, actual %0d", w.upper_dot, g.upper_dot);
            errors++;
        end
        if (g.mode !== w.mode)
        begin
            $error("mode: expected %0d, actual %0d", w.mode, g.mode);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.time_hold_ms = TIME_HOLD_RST;
            regs.date_hold_ms = DATE_HOLD_RST;
            regs.roll_step_ms = ROLL_STEP_RST;
            regs.settle_steps = SETTLE_RST;
            cur_mode     = MODE_ROLL;
            toward_date  = 1'b0;
            shown_digits = '0;
            roll_cnt     = '0;
            since_change = '0;
            since_roll   = ROLL_MAX;
            display_q.delete();
            errors   = 0;
            pending  = 0;
            checked  = 0;
            arrivals = 0;
            switches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_TIME_HOLD: regs.time_hold_ms = cfg_data;
                    REG_DATE_HOLD: regs.date_hold_ms = cfg_data;
                    REG_ROLL_STEP: regs.roll_step_ms = cfg_data[7:0];
                    REG_SETTLE:    regs.settle_steps = cfg_data[7:0];
                    default: ;
                endcase
            end
            // retire the oldest expectation before queuing this edge's new item
            if (m_tvalid && m_tready)
            begin
                got = display_t'(m_tdata[SHOW_W-1:0]);
                if (display_q.size() == 0)
                begin
                    $error("display item arrived with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = display_q.pop_front();
                    check_display(want, got);
                end
                checked++;
            end
            if (s_tvalid && s_tready)
                display_q.push_back(advance_display(tick_t'(s_tdata[TICK_W-1:0])));
            pending = display_q.size();
        end
    end

endmodule

/* sim/digit_display_mode_sequencer_tb.sv */
module digit_display_mode_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dds_pkg::*;

    localparam int LAMPS = 4;
    localparam int IN_W  = ((2 * LAMPS * DIGIT_W + 1 + 7) / 8) * 8;
    localparam int OUT_W = ((LAMPS * DIGIT_W + 2 + MODE_W + 7) / 8) * 8;
    localparam int PAD_W = IN_W - (2 * LAMPS * DIGIT_W + 1);
    localparam int HOLD_OFF_CYCLES = 64;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    // time_digit_0..3, date_digit_0..3, second_odd, zero pad
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // shown_digit_0..3, lower_dot, upper_dot, mode, zero pad
    logic [OUT_W-1:0]  m_tdata;

    int errors;
    int pending;
    int checked;
    int arrivals;
    int switches;

    int   ticks_sent;
    int   settings_used;
    int   hold_off_reqs;

    logic [LAMPS-1:0][DIGIT_W-1:0] held_time;
    logic [LAMPS-1:0][DIGIT_W-1:0] held_date;
    logic                          held_odd;

    digit_display_mode_sequencer #(.LAMPS(LAMPS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dds_display_checker #(.LAMPS(LAMPS), .IN_W(IN_W), .OUT_W(OUT_W)) display_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked),
        .arrivals (arrivals),
        .switches (switches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // idling schedule: sender sparse / receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        if (ticks_sent < 530)
            return 7;
        else if (ticks_sent < 1060)
            return 82;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (ticks_sent < 530)
            return 82;
        else if (ticks_sent < 1060)
            return 7;
        return 0;
    endfunction

    initial
    begin
        int holds_done;
        holds_done = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_reqs != holds_done)
            begin
                holds_done = hold_off_reqs;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    task automatic send_tick(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < sender_idle_pct())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // drain every outstanding display item, then reprogram while idle
    task automatic apply_setting(input logic [15:0] th, input logic [15:0] dh,
                                 input logic [15:0] rs, input logic [15:0] st);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
        write_reg(REG_TIME_HOLD, th);
        write_reg(REG_DATE_HOLD, dh);
        write_reg(REG_ROLL_STEP, rs);
        write_reg(REG_SETTLE, st);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // mostly a steady clock reading with occasional digit changes; a few glitch items
    function automatic logic [IN_W-1:0] next_tick();
        logic [2*LAMPS*DIGIT_W:0] raw;
        if ($urandom_range(99) < 3)
        begin
            raw = {1'($urandom_range(1)), 32'($urandom())};
            return {{PAD_W{1'b0}}, raw};
        end
        if ($urandom_range(15) == 0)
            held_time[$urandom_range(LAMPS-1)] = DIGIT_W'($urandom_range(9));
        if ($urandom_range(15) == 0)
            held_date[$urandom_range(LAMPS-1)] = DIGIT_W'($urandom_range(9));
        if ($urandom_range(199) == 0)
            held_date[$urandom_range(LAMPS-1)] = DIGIT_W'($urandom_range(15, 10));
        if ($urandom_range(3) == 0)
            held_odd = ~held_odd;
        return {{PAD_W{1'b0}}, held_odd, held_date, held_time};
    endfunction

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            // stall the output long enough to back up the input
            if (k == 40)
                hold_off_reqs++;
            send_tick(next_tick());
        end
    endtask

    initial
    begin
        logic [15:0] tw;
        logic [15:0] dw;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        ticks_sent = 0;
        settings_used = 0;
        held_time  = '0;
        held_date  = '0;
        held_odd   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // every tick rolls, matching digits hold after the first step, date switches at once
        apply_setting(16'd2, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 24; k++)
        begin
            if (k < 8)
            begin
                tw = 16'h1111;
                dw = 16'h9999;
            end
            else if (k < 16)
            begin
                tw = 16'h9050;
                dw = 16'h0000;
            end
            else if (k < 20)
            begin
                tw = 16'h0000;
                dw = 16'h9090;
            end
            else if (k < 22)
            begin
                // out of range targets: never matched, shown raw in time or date mode
                tw = 16'hFFFF;
                dw = 16'hAFAF;
            end
            else
            begin
                tw = 16'h0909;
                dw = 16'h1234;
            end
            send_tick({{PAD_W{1'b0}}, 1'(k % 2), dw, tw});
        end

        apply_setting(16'd10, 16'd6, 16'd1, 16'd0);
        run_random(350);
        apply_setting(16'd25, 16'd40, 16'hA503, 16'h5A04);
        run_random(350);
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(120);
        apply_setting(16'd0, 16'd0, 16'd0, 16'd2);
        run_random(250);
        // settle never passed: roll count wraps unless digits line up by chance
        apply_setting(16'd5, 16'd3, 16'd1, 16'd255);
        run_random(350);
        apply_setting(TIME_HOLD_RST, DATE_HOLD_RST, {8'd0, ROLL_STEP_RST}, {8'd0, SETTLE_RST});
        run_random(150);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d ticks under %0d register settings incl. extremes, masked writes",
                 ticks_sent, settings_used);
        $display("summary: %0d display items compared, %0d roll arrivals, %0d mode switches",
                 checked, arrivals, switches);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
